[rtl/rcpp_pkg.sv]
// Shared types and constants for the RTCP compound packet parser.
package rcpp_pkg;

  // Field widths.
  localparam int POS_W = 18;
  localparam int CNT_W = POS_W + 1;

  // RTCP sender report packet type.
  localparam logic [7:0] SR_TYPE = 8'd200;

  // Bytes needed before a report is complete: common header, and sender report.
  localparam logic [CNT_W-1:0] HDR_NEED = CNT_W'(8);
  localparam logic [CNT_W-1:0] SR_NEED  = CNT_W'(28);

  // Byte positions of the header and sender-report count fields within a sub-packet.
  localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SSRC_END = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PKT_BEG  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_PKT_END  = POS_W'(23);
  localparam logic [POS_W-1:0] POS_OCT_BEG  = POS_W'(24);
  localparam logic [POS_W-1:0] POS_OCT_END  = POS_W'(27);

  // One input byte.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_datagram;
  } rcpp_item_t;

  // One sub-packet report.
  typedef struct packed {
    logic [31:0]      source_id;
    logic [1:0]       proto_version;
    logic             padding_bit;
    logic [4:0]       report_count;
    logic [7:0]       packet_type;
    logic [POS_W-1:0] payload_bytes;
    logic             is_sender_report;
    logic [31:0]      sent_packet_count;
    logic [31:0]      sent_octet_count;
    logic             short_packet;
  } rcpp_report_t;

endpackage

[rtl/rcpp_in_reg.sv]
// Input register stage for incoming datagram bytes.
module rcpp_in_reg
  import rcpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rcpp_item_t in_item,
  output logic       item_valid,
  output rcpp_item_t item,
  input  logic       item_take
);

  logic       valid_r;
  logic       valid_nxt;
  rcpp_item_t item_r;

  // The stage can load when empty or when its byte is consumed this cycle.
  assign in_ready  = !valid_r || item_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only on a transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/rcpp_core.sv]
// Sub-packet tracking, field capture and report formation.
module rcpp_core
  import rcpp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  rcpp_item_t   item,
  output logic         item_take,
  output logic         res_valid,
  output rcpp_report_t res,
  input  logic         res_ready
);

  logic [POS_W-1:0] byte_position_r, byte_position_nxt;
  logic [15:0]      length_word_r, length_word_nxt;
  logic [7:0]       first_header_byte_r, first_header_byte_nxt;
  logic [7:0]       type_byte_r, type_byte_nxt;
  logic [31:0]      ssrc_r, ssrc_nxt;
  logic [31:0]      pkt_count_r, pkt_count_nxt;
  logic [31:0]      oct_count_r, oct_count_nxt;

  logic [POS_W-1:0] pos;
  logic [7:0]       b;
  logic [POS_W-1:0] span_last;
  logic [CNT_W-1:0] received;
  logic             closing;
  logic             is_sr;
  logic             sr_full;
  logic [CNT_W-1:0] needed;

  assign pos = byte_position_r;
  assign b   = item.byte_value;

  // Capture the current byte into the field its position selects.
  always_comb begin
    first_header_byte_nxt = first_header_byte_r;
    type_byte_nxt         = type_byte_r;
    length_word_nxt       = length_word_r;
    ssrc_nxt              = ssrc_r;
    pkt_count_nxt         = pkt_count_r;
    oct_count_nxt         = oct_count_r;
    priority if (pos == '0) begin
      first_header_byte_nxt = b;
      type_byte_nxt         = '0;
      length_word_nxt       = '0;
      ssrc_nxt              = '0;
      pkt_count_nxt         = '0;
      oct_count_nxt         = '0;
    end else if (pos == POS_TYPE) begin
      type_byte_nxt = b;
    end else if (pos == POS_LEN_HI) begin
      length_word_nxt = {b, 8'd0};
    end else if (pos == POS_LEN_LO) begin
      length_word_nxt = {length_word_r[15:8], b};
    end else if (pos <= POS_SSRC_END) begin
      ssrc_nxt = {ssrc_r[23:0], b};
    end else if (type_byte_r == SR_TYPE && pos >= POS_PKT_BEG && pos <= POS_PKT_END) begin
      pkt_count_nxt = {pkt_count_r[23:0], b};
    end else if (type_byte_r == SR_TYPE && pos >= POS_OCT_BEG && pos <= POS_OCT_END) begin
      oct_count_nxt = {oct_count_r[23:0], b};
    end
  end

  // A sub-packet closes at the end of its span or at the end of the datagram.
  assign span_last = {length_word_nxt, 2'b11};
  assign closing   = item.end_of_datagram || (pos >= POS_LEN_LO && pos == span_last);

  // Bytes that close a sub-packet wait for room in the result register.
  assign item_take = item_valid && (res_ready || !closing);
  assign res_valid = item_take && closing;

  assign byte_position_nxt = closing ? '0 : POS_W'({1'b0, pos} + CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r     <= '0;
      length_word_r       <= '0;
      first_header_byte_r <= '0;
      type_byte_r         <= '0;
      ssrc_r              <= '0;
      pkt_count_r         <= '0;
      oct_count_r         <= '0;
    end else if (item_take) begin
      byte_position_r     <= byte_position_nxt;
      length_word_r       <= length_word_nxt;
      first_header_byte_r <= first_header_byte_nxt;
      type_byte_r         <= type_byte_nxt;
      ssrc_r              <= ssrc_nxt;
      pkt_count_r         <= pkt_count_nxt;
      oct_count_r         <= oct_count_nxt;
    end
  end

  // Report fields; those not yet received read as zero.
  assign received = {1'b0, pos} + CNT_W'(1);
  assign is_sr    = (pos != '0) && (type_byte_nxt == SR_TYPE);
  assign sr_full  = is_sr && (received >= SR_NEED);
  assign needed   = is_sr ? SR_NEED : HDR_NEED;

  always_comb begin
    res.source_id         = (received >= HDR_NEED) ? ssrc_nxt : '0;
    res.proto_version     = first_header_byte_nxt[7:6];
    res.padding_bit       = first_header_byte_nxt[5];
    res.report_count      = first_header_byte_nxt[4:0];
    res.packet_type       = (pos != '0) ? type_byte_nxt : '0;
    res.payload_bytes     = (pos >= POS_LEN_LO) ? {length_word_nxt, 2'b00} : '0;
    res.is_sender_report  = is_sr;
    res.sent_packet_count = sr_full ? pkt_count_nxt : '0;
    res.sent_octet_count  = sr_full ? oct_count_nxt : '0;
    res.short_packet      = received < needed;
  end

endmodule

[rtl/rcpp_out_reg.sv]
// Result register stage holding one finished report.
module rcpp_out_reg
  import rcpp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  output logic         res_ready,
  input  rcpp_report_t res,
  output logic         out_valid,
  input  logic         out_stall,
  output rcpp_report_t out_report
);

  logic         valid_r;
  logic         valid_nxt;
  rcpp_report_t report_r;

  // Room exists when empty or when the held report transfers this cycle.
  assign res_ready = !valid_r || !out_stall;
  assign valid_nxt = res_ready ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      report_r <= res;
    end
  end

  assign out_valid  = valid_r;
  assign out_report = report_r;

endmodule

[rtl/rtcp_compound_packet_parser.sv]
// Top level of the RTCP compound packet parser.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   byte_value, end_of_datagram
//   out_     output     out_valid/out_stall one report per sub-packet
//
// One byte is taken per cycle while in_stall is low; the byte that closes a
// sub-packet passes the input register, then the result register, to its report.
// Reset is synchronous and active low; it clears the valid bits and the
// sub-packet position, so the first byte after reset starts a new header.
// While out_stall holds a report, bytes that do not close a sub-packet keep
// flowing; a closing byte waits in the input register for room.
module rtcp_compound_packet_parser
  import rcpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte_value,
  input  logic             in_end_of_datagram,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_source_id,
  output logic [1:0]       out_proto_version,
  output logic             out_padding_bit,
  output logic [4:0]       out_report_count,
  output logic [7:0]       out_packet_type,
  output logic [POS_W-1:0] out_payload_bytes,
  output logic             out_is_sender_report,
  output logic [31:0]      out_sent_packet_count,
  output logic [31:0]      out_sent_octet_count,
  output logic             out_short_packet
);

  logic         in_ready;
  rcpp_item_t   in_item;
  logic         item_valid;
  rcpp_item_t   item;
  logic         item_take;
  logic         res_valid;
  logic         res_ready;
  rcpp_report_t res;
  rcpp_report_t out_report;

  assign in_item.byte_value      = in_byte_value;
  assign in_item.end_of_datagram = in_end_of_datagram;
  assign in_stall                = !in_ready;

  rcpp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rcpp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  rcpp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_report (out_report)
  );

  // Unpack the held report onto the result ports.
  assign out_source_id         = out_report.source_id;
  assign out_proto_version     = out_report.proto_version;
  assign out_padding_bit       = out_report.padding_bit;
  assign out_report_count      = out_report.report_count;
  assign out_packet_type       = out_report.packet_type;
  assign out_payload_bytes     = out_report.payload_bytes;
  assign out_is_sender_report  = out_report.is_sender_report;
  assign out_sent_packet_count = out_report.sent_packet_count;
  assign out_sent_octet_count  = out_report.sent_octet_count;
  assign out_short_packet      = out_report.short_packet;

endmodule
